### rtl/adc_rbfc_pkg.sv
// ----------------------------------------------------------------------------
// adc_rbfc_pkg
// Shared types, register codes and the CRC-8 step for the ADC read-back
// frame checker.
// ----------------------------------------------------------------------------
package adc_rbfc_pkg;

   // Register indexes on the configuration port
   localparam logic [1:0] CSR_STATUS_ENABLED  = 2'd0;
   localparam logic [1:0] CSR_CHECK_MODE      = 2'd1;
   localparam logic [1:0] CSR_CHECKSUM_OFFSET = 2'd2;
   localparam logic [1:0] CSR_CRC_POLYNOMIAL  = 2'd3;

   // Check byte modes
   localparam logic [1:0] CHECK_NONE = 2'd0;
   localparam logic [1:0] CHECK_SUM  = 2'd1;
   localparam logic [1:0] CHECK_CRC  = 2'd2;

   // Reset values of the registers
   localparam logic       STATUS_ENABLED_RESET  = 1'b0;
   localparam logic [1:0] CHECK_MODE_RESET      = CHECK_SUM;
   localparam logic [7:0] CHECKSUM_OFFSET_RESET = 8'd155;
   localparam logic [7:0] CRC_POLYNOMIAL_RESET  = 8'd7;

   // Frame geometry
   localparam logic [2:0] WIDE_DATA_BYTES   = 3'd4;
   localparam logic [2:0] NARROW_DATA_BYTES = 3'd3;
   localparam logic [2:0] DATA_SLOT_BYTES   = 3'd4;

   typedef struct packed {
      logic       status_enabled;
      logic [1:0] check_mode;
      logic [7:0] checksum_offset;
      logic [7:0] crc_polynomial;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic        [7:0]  status_byte;
      logic               check_failed;
      logic               from_narrow;
   } rsp_type;

   // One byte of CRC-8, MSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/adc_rbfc_csr.sv
// ----------------------------------------------------------------------------
// adc_rbfc_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module adc_rbfc_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_write_data,
   output adc_rbfc_pkg::cfg_type cfg
);

   adc_rbfc_pkg::cfg_type cfg_ff;
   adc_rbfc_pkg::cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            adc_rbfc_pkg::CSR_STATUS_ENABLED:  cfg_in.status_enabled  = csr_write_data[0];
            adc_rbfc_pkg::CSR_CHECK_MODE:      cfg_in.check_mode      = csr_write_data[1:0];
            adc_rbfc_pkg::CSR_CHECKSUM_OFFSET: cfg_in.checksum_offset = csr_write_data;
            adc_rbfc_pkg::CSR_CRC_POLYNOMIAL:  cfg_in.crc_polynomial  = csr_write_data;
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.status_enabled  <= adc_rbfc_pkg::STATUS_ENABLED_RESET;
         cfg_ff.check_mode      <= adc_rbfc_pkg::CHECK_MODE_RESET;
         cfg_ff.checksum_offset <= adc_rbfc_pkg::CHECKSUM_OFFSET_RESET;
         cfg_ff.crc_polynomial  <= adc_rbfc_pkg::CRC_POLYNOMIAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/adc_rbfc_frame.sv
// ----------------------------------------------------------------------------
// adc_rbfc_frame
// Input register and frame tracker: assembles the sample, runs the sum and
// the CRC, and flags the frame end with a finished result.
// ----------------------------------------------------------------------------
module adc_rbfc_frame (
   input  logic                  clock,
   input  logic                  reset,
   input  adc_rbfc_pkg::cfg_type cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   input  logic                  req_frame_start,
   input  logic                  req_adc_select,
   input  logic                  out_free,
   output logic                  res_valid,
   output adc_rbfc_pkg::rsp_type res
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       in_select_ff;

   // Frame state
   logic        active_ff,  active_in;
   logic [2:0]  pos_ff,     pos_in;
   logic        chan_ff,    chan_in;
   logic        fstat_ff,   fstat_in;
   logic [1:0]  fcheck_ff,  fcheck_in;
   logic [31:0] shift_ff,   shift_in;
   logic [7:0]  status_ff,  status_in;
   logic [7:0]  sum_ff,     sum_in;
   logic [7:0]  crc_ff,     crc_in;

   logic       advance;
   logic       take;
   logic [2:0] ndata;
   logic [2:0] rel;
   logic [3:0] len;
   logic       have_check;
   logic       last;
   logic       failed;

   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   assign in_valid_in = take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff   <= req_rx_byte;
         in_start_ff  <= req_frame_start;
         in_select_ff <= req_adc_select;
      end
   end

   // Per-byte frame update
   always_comb begin
      active_in  = active_ff;
      pos_in     = pos_ff;
      chan_in    = chan_ff;
      fstat_in   = fstat_ff;
      fcheck_in  = fcheck_ff;
      shift_in   = shift_ff;
      status_in  = status_ff;
      sum_in     = sum_ff;
      crc_in     = crc_ff;
      have_check = 1'b0;
      failed     = 1'b0;
      last       = 1'b0;

      // new frame restarts all running values but the held status byte
      if (in_start_ff) begin
         active_in = 1'b1;
         pos_in    = 3'd0;
         chan_in   = in_select_ff;
         fstat_in  = cfg.status_enabled;
         fcheck_in = cfg.check_mode;
         shift_in  = 32'd0;
         sum_in    = 8'd0;
         crc_in    = 8'd0;
      end

      ndata = chan_in ? adc_rbfc_pkg::NARROW_DATA_BYTES : adc_rbfc_pkg::WIDE_DATA_BYTES;
      len   = 4'(fstat_in) + 4'(adc_rbfc_pkg::DATA_SLOT_BYTES)
            + 4'(fcheck_in != adc_rbfc_pkg::CHECK_NONE);
      rel   = pos_in - 3'(fstat_in);

      if (active_in) begin
         if (fstat_in && pos_in == 3'd0) begin
            status_in = in_byte_ff;
         end else if (rel < ndata) begin
            shift_in = {shift_in[23:0], in_byte_ff};
            sum_in   = sum_in + in_byte_ff;
            crc_in   = adc_rbfc_pkg::crc8_byte(crc_in, in_byte_ff, cfg.crc_polynomial);
         end else if (rel >= adc_rbfc_pkg::DATA_SLOT_BYTES) begin
            have_check = 1'b1;
         end

         // mode three carries a check byte that is never compared
         if (have_check) begin
            if (fcheck_in == adc_rbfc_pkg::CHECK_SUM) begin
               failed = (sum_in + cfg.checksum_offset) != in_byte_ff;
            end else if (fcheck_in == adc_rbfc_pkg::CHECK_CRC) begin
               failed = crc_in != in_byte_ff;
            end
         end

         last = (4'(pos_in) + 4'd1) >= len;
         if (last) begin
            active_in = 1'b0;
            pos_in    = 3'd0;
         end else begin
            pos_in = pos_in + 3'd1;
         end
      end
   end

   assign res_valid        = advance && last;
   assign res.sample_value = shift_in;
   assign res.status_byte  = status_in;
   assign res.check_failed = failed;
   assign res.from_narrow  = chan_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= 3'd0;
         chan_ff   <= 1'b0;
         fstat_ff  <= 1'b0;
         fcheck_ff <= adc_rbfc_pkg::CHECK_NONE;
         shift_ff  <= 32'd0;
         status_ff <= 8'd0;
         sum_ff    <= 8'd0;
         crc_ff    <= 8'd0;
      end else if (advance) begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         chan_ff   <= chan_in;
         fstat_ff  <= fstat_in;
         fcheck_ff <= fcheck_in;
         shift_ff  <= shift_in;
         status_ff <= status_in;
         sum_ff    <= sum_in;
         crc_ff    <= crc_in;
      end
   end

endmodule

### rtl/adc_rbfc_out.sv
// ----------------------------------------------------------------------------
// adc_rbfc_out
// Result register toward the response channel.
// ----------------------------------------------------------------------------
module adc_rbfc_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  adc_rbfc_pkg::rsp_type res,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_sample_value,
   output logic [7:0]            rsp_status_byte,
   output logic                  rsp_check_failed,
   output logic                  rsp_from_narrow
);

   logic                  valid_ff, valid_in;
   adc_rbfc_pkg::rsp_type data_ff;

   // free when empty or being taken this cycle
   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = out_free ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_sample_value = data_ff.sample_value;
   assign rsp_status_byte  = data_ff.status_byte;
   assign rsp_check_failed = data_ff.check_failed;
   assign rsp_from_narrow  = data_ff.from_narrow;

endmodule

### rtl/adc_readback_frame_checker_core.sv
// ----------------------------------------------------------------------------
// adc_readback_frame_checker_core
// Checks ADC read-back frames byte by byte and reports the assembled sample,
// the latest status byte and a check mismatch flag at each frame end.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   rx_byte, frame_start, adc_select
//   rsp      out        rsp_valid/stall   sample_value, status_byte,
//                                         check_failed, from_narrow
//   csr      in         csr_write_enable  csr_index, csr_write_data
//
// One item per cycle sustained while rsp is not stalled; the last byte of
// its frame passes the input register, then the result register, before
// rsp_valid rises for that frame.
// Reset is synchronous and clears frame state and registers to defaults.
// A stall on rsp holds the result register and backs up to req_stall.
// ----------------------------------------------------------------------------
module adc_readback_frame_checker_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   input  logic               req_adc_select,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_sample_value,
   output logic [7:0]         rsp_status_byte,
   output logic               rsp_check_failed,
   output logic               rsp_from_narrow,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_write_data
);

   adc_rbfc_pkg::cfg_type cfg;
   adc_rbfc_pkg::rsp_type res;
   logic                  res_valid;
   logic                  out_free;

   adc_rbfc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   adc_rbfc_frame u_frame (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .req_adc_select  (req_adc_select),
      .out_free        (out_free),
      .res_valid       (res_valid),
      .res             (res)
   );

   adc_rbfc_out u_out (
      .clock            (clock),
      .reset            (reset),
      .res_valid        (res_valid),
      .res              (res),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_value (rsp_sample_value),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_check_failed (rsp_check_failed),
      .rsp_from_narrow  (rsp_from_narrow)
   );

endmodule

### bench/adc_readback_result_checker.sv
// ----------------------------------------------------------------------------
// adc_readback_result_checker
// Watches the byte channel, the result channel and the register port of the
// ADC read-back frame checker. It keeps its own copy of the register settings
// and of the frame state, predicts one result per completed frame, and
// compares every result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module adc_readback_result_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   input  logic               req_adc_select,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_sample_value,
   input  logic [7:0]         rsp_status_byte,
   input  logic               rsp_check_failed,
   input  logic               rsp_from_narrow,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_write_data,
   output int                 mismatches,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Register copy as seen on the write port
   adc_rbfc_pkg::cfg_type regs;

   // Frame tracking
   logic       in_frame;
   logic [2:0] next_pos;
   logic       narrow_frame;
   logic       frame_has_status;
   logic [1:0] frame_mode;
   logic [31:0] sample_acc;
   logic [7:0] held_status;
   logic [7:0] byte_sum;
   logic [7:0] byte_crc;

   // Predicted results, oldest first
   adc_rbfc_pkg::rsp_type pending_samples[$];

   // CRC-8 over one byte, fed one message bit at a time
   function automatic logic [7:0] crc_fold(input logic [7:0] crc_in,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
      logic [7:0] r;
      logic       fb;
      r = crc_in;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ data[i];
         r  = {r[6:0], 1'b0};
         if (fb) begin
            r = r ^ poly;
         end
      end
      return r;
   endfunction

   // Advance the frame by one accepted item; queue a result at frame end
   task automatic absorb_byte(input logic [7:0] b, input logic start, input logic sel);
      logic [2:0] frame_len;
      logic [2:0] slot;
      logic [2:0] data_bytes;
      logic [7:0] got_check;
      logic       has_check;
      logic [7:0] sum_total;
      logic       failed;
      adc_rbfc_pkg::rsp_type r;
      if (start) begin
         in_frame         = 1'b1;
         next_pos         = 3'd0;
         narrow_frame     = sel;
         frame_has_status = regs.status_enabled;
         frame_mode       = regs.check_mode;
         sample_acc       = '0;
         byte_sum         = '0;
         byte_crc         = '0;
      end
      if (in_frame) begin
         frame_len = 3'd4 + {2'd0, frame_has_status}
                   + {2'd0, frame_mode != adc_rbfc_pkg::CHECK_NONE};
         has_check = 1'b0;
         got_check = '0;
         if (frame_has_status && next_pos == 3'd0) begin
            held_status = b;
         end else begin
            slot       = next_pos - {2'd0, frame_has_status};
            data_bytes = narrow_frame ? adc_rbfc_pkg::NARROW_DATA_BYTES
                                      : adc_rbfc_pkg::WIDE_DATA_BYTES;
            if (slot < data_bytes) begin
               sample_acc = {sample_acc[23:0], b};
               byte_sum   = byte_sum + b;
               byte_crc   = crc_fold(byte_crc, b, regs.crc_polynomial);
            end else if (slot >= adc_rbfc_pkg::DATA_SLOT_BYTES) begin
               got_check = b;
               has_check = 1'b1;
            end
            // narrow pad byte falls through untouched
         end
         if ({1'b0, next_pos} + 4'd1 >= {1'b0, frame_len}) begin
            failed = 1'b0;
            if (has_check) begin
               sum_total = byte_sum + regs.checksum_offset;
               case (frame_mode)
                  adc_rbfc_pkg::CHECK_SUM: failed = (sum_total != got_check);
                  adc_rbfc_pkg::CHECK_CRC: failed = (byte_crc != got_check);
                  default:                 failed = 1'b0;
               endcase
            end
            r.sample_value = sample_acc;
            r.status_byte  = held_status;
            r.check_failed = failed;
            r.from_narrow  = narrow_frame;
            pending_samples.push_back(r);
            in_frame = 1'b0;
            next_pos = 3'd0;
         end else begin
            next_pos = next_pos + 3'd1;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      adc_rbfc_pkg::rsp_type want;
      if (reset) begin
         regs.status_enabled  = adc_rbfc_pkg::STATUS_ENABLED_RESET;
         regs.check_mode      = adc_rbfc_pkg::CHECK_MODE_RESET;
         regs.checksum_offset = adc_rbfc_pkg::CHECKSUM_OFFSET_RESET;
         regs.crc_polynomial  = adc_rbfc_pkg::CRC_POLYNOMIAL_RESET;
         in_frame         = 1'b0;
         next_pos         = '0;
         narrow_frame     = 1'b0;
         frame_has_status = 1'b0;
         frame_mode       = adc_rbfc_pkg::CHECK_NONE;
         sample_acc       = '0;
         held_status      = '0;
         byte_sum         = '0;
         byte_crc         = '0;
         pending_samples.delete();
         mismatches       = 0;
      end else begin
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               adc_rbfc_pkg::CSR_STATUS_ENABLED:
                  regs.status_enabled  = csr_write_data[0];
               adc_rbfc_pkg::CSR_CHECK_MODE:
                  regs.check_mode      = csr_write_data[1:0];
               adc_rbfc_pkg::CSR_CHECKSUM_OFFSET:
                  regs.checksum_offset = csr_write_data;
               adc_rbfc_pkg::CSR_CRC_POLYNOMIAL:
                  regs.crc_polynomial  = csr_write_data;
               default: ;
            endcase
         end
         // accepted byte
         if (req_valid && !req_stall) begin
            absorb_byte(req_rx_byte, req_frame_start, req_adc_select);
         end
         // accepted result
         if (rsp_valid && !rsp_stall) begin
            if (pending_samples.size() == 0) begin
               $display("%0t: unexpected result, sample_value %0d status_byte %0d",
                        $time, rsp_sample_value, rsp_status_byte);
               mismatches++;
            end else begin
               want = pending_samples.pop_front();
               if (want.sample_value !== rsp_sample_value) begin
                  $display("%0t: sample_value expected %0d, actual %0d",
                           $time, want.sample_value, rsp_sample_value);
                  mismatches++;
               end
               if (want.status_byte !== rsp_status_byte) begin
                  $display("%0t: status_byte expected %0d, actual %0d",
                           $time, want.status_byte, rsp_status_byte);
                  mismatches++;
               end
               if (want.check_failed !== rsp_check_failed) begin
                  $display("%0t: check_failed expected %0d, actual %0d",
                           $time, want.check_failed, rsp_check_failed);
                  mismatches++;
               end
               if (want.from_narrow !== rsp_from_narrow) begin
                  $display("%0t: from_narrow expected %0d, actual %0d",
                           $time, want.from_narrow, rsp_from_narrow);
                  mismatches++;
               end
            end
         end
      end
      outstanding = pending_samples.size();
   end

endmodule

### bench/tb_adc_readback_frame_checker_core.sv
// ----------------------------------------------------------------------------
// tb_adc_readback_frame_checker_core
// Drives ADC read-back frames into the frame checker under several register
// settings: a directed opening (field extremes, stray bytes, abandoned and
// register-straddling frames), then random well-formed, truncated and noisy
// frames with random idle on both channels and one long result hold-off.
// A separate checker module predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_adc_readback_frame_checker_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CHECK_UNCOMPARED = 2'd3;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_ITEMS   = 50;
   localparam int PHASE_COUNT   = 8;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_rx_byte;
   logic               req_frame_start;
   logic               req_adc_select;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_sample_value;
   logic [7:0]         rsp_status_byte;
   logic               rsp_check_failed;
   logic               rsp_from_narrow;
   logic               csr_write_enable;
   logic [1:0]         csr_index;
   logic [7:0]         csr_write_data;

   int      mismatches;
   int      outstanding;
   int      cycle_count   = 0;
   int      req_idle_pct  = 17;
   int      rsp_idle_pct  = 17;
   logic    hold_request  = 1'b0;
   int      phase_items;
   adc_rbfc_pkg::cfg_type cur_cfg;

   adc_readback_frame_checker_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_frame_start  (req_frame_start),
      .req_adc_select   (req_adc_select),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_value (rsp_sample_value),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_check_failed (rsp_check_failed),
      .rsp_from_narrow  (rsp_from_narrow),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   adc_readback_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_frame_start  (req_frame_start),
      .req_adc_select   (req_adc_select),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_value (rsp_sample_value),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_check_failed (rsp_check_failed),
      .rsp_from_narrow  (rsp_from_narrow),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: random stall, plus a counted hold-off on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
         @(negedge clock);
      end
   end

   // CRC-8, MSB first, for building good check bytes
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      repeat (8) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // Offer one item and hold it until accepted; called at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic start, input logic sel);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= b;
      req_frame_start <= start;
      req_adc_select  <= sel;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Send a frame under the current settings; keep <= 0 sends all of it
   task automatic send_frame(input logic sel, input logic [31:0] word,
                             input logic [7:0] stat_b, input int keep, input logic good);
      logic [7:0] seq [6];
      logic [7:0] sum;
      logic [7:0] crc;
      logic [7:0] chk;
      int         total;
      sum   = cur_cfg.checksum_offset;
      crc   = 8'h00;
      total = 0;
      for (int i = 0; i < (sel ? 3 : 4); i++) begin
         sum = sum + word[31 - 8 * i -: 8];
         crc = crc8_step(crc, word[31 - 8 * i -: 8], cur_cfg.crc_polynomial);
      end
      chk = (cur_cfg.check_mode == adc_rbfc_pkg::CHECK_CRC) ? crc : sum;
      if (!good) begin
         chk = chk ^ (8'h01 << $urandom_range(7));
      end
      if (cur_cfg.status_enabled) begin
         seq[total] = stat_b;
         total++;
      end
      for (int i = 0; i < 4; i++) begin
         seq[total] = word[31 - 8 * i -: 8];
         total++;
      end
      if (cur_cfg.check_mode != adc_rbfc_pkg::CHECK_NONE) begin
         seq[total] = chk;
         total++;
      end
      if (keep <= 0 || keep > total) begin
         keep = total;
      end
      // channel select only matters on the first byte
      for (int i = 0; i < keep; i++) begin
         send_byte(seq[i], i == 0, (i == 0) ? sel : 1'($urandom));
      end
      phase_items += keep;
   endtask

   // Mostly full frames, some truncated, some stray bytes
   task automatic random_burst();
      int          pick;
      int          len;
      logic [31:0] word;
      pick = $urandom_range(99);
      len  = 4 + cur_cfg.status_enabled + (cur_cfg.check_mode != adc_rbfc_pkg::CHECK_NONE);
      case ($urandom_range(9))
         0:       word = 32'h0000_0000;
         1:       word = 32'hFFFF_FFFF;
         2:       word = 32'h8000_0000;
         3:       word = 32'h7FFF_FFFF;
         default: word = $urandom;
      endcase
      if (pick < 10) begin
         send_byte(8'($urandom), 1'b0, 1'($urandom));
      end else if (pick < 22) begin
         send_frame(1'($urandom), word, 8'($urandom), $urandom_range(len - 1, 1), 1'b1);
      end else begin
         send_frame(1'($urandom), word, 8'($urandom), 0, $urandom_range(3) != 0);
      end
   endtask

   task automatic put_reg(input logic [1:0] idx, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   task automatic write_config(input adc_rbfc_pkg::cfg_type c);
      put_reg(adc_rbfc_pkg::CSR_STATUS_ENABLED, {7'd0, c.status_enabled});
      put_reg(adc_rbfc_pkg::CSR_CHECK_MODE, {6'd0, c.check_mode});
      put_reg(adc_rbfc_pkg::CSR_CHECKSUM_OFFSET, c.checksum_offset);
      put_reg(adc_rbfc_pkg::CSR_CRC_POLYNOMIAL, c.crc_polynomial);
      csr_write_enable <= 1'b0;
      cur_cfg = c;
   endtask

   // Stop offering and let every outstanding result come out
   task automatic go_quiet();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Stimulus
   initial begin : stimulus
      adc_rbfc_pkg::cfg_type plan [PHASE_COUNT];
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_rx_byte      <= 8'h00;
      req_frame_start  <= 1'b0;
      req_adc_select   <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= adc_rbfc_pkg::CSR_STATUS_ENABLED;
      csr_write_data   <= 8'h00;
      cur_cfg = '{adc_rbfc_pkg::STATUS_ENABLED_RESET, adc_rbfc_pkg::CHECK_MODE_RESET,
                  adc_rbfc_pkg::CHECKSUM_OFFSET_RESET, adc_rbfc_pkg::CRC_POLYNOMIAL_RESET};
      plan[0] = '{1'b1, adc_rbfc_pkg::CHECK_CRC,  8'h00, 8'hFF};
      plan[1] = '{1'b0, adc_rbfc_pkg::CHECK_NONE, 8'hFF, 8'h00};
      plan[2] = '{1'b1, CHECK_UNCOMPARED,         8'h5A, 8'h07};
      plan[3] = '{1'b0, adc_rbfc_pkg::CHECK_SUM,  8'hFF, 8'h80};
      plan[4] = '{1'b1, adc_rbfc_pkg::CHECK_SUM,  8'h00, 8'h31};
      plan[5] = '{1'b0, adc_rbfc_pkg::CHECK_CRC,  8'h9B, 8'h07};
      plan[6] = '{1'($urandom), 2'($urandom), 8'($urandom), 8'($urandom)};
      plan[7] = '{1'($urandom), 2'($urandom), 8'($urandom), 8'($urandom)};
      phase_items = 0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed opening under reset settings
      send_byte(8'hA5, 1'b0, 1'b0);                          // stray byte, no frame
      send_frame(1'b0, 32'h0000_0000, 8'h00, 0, 1'b1);
      send_frame(1'b1, 32'hFFFF_FFFF, 8'hFF, 0, 1'b0);       // narrow, bad check
      send_frame(1'b0, 32'h8000_0000, 8'h00, 2, 1'b1);       // abandoned by next start
      send_frame(1'b0, 32'h7FFF_FFFF, 8'h00, 0, 1'b1);
      send_frame(1'b1, 32'h8000_00FF, 8'h00, 0, 1'b1);
      send_byte(8'h3C, 1'b0, 1'b1);                          // stray byte after frame end
      go_quiet();

      // Registers change in the middle of a frame: old mode stays latched
      send_frame(1'b1, 32'h1234_5678, 8'h00, 3, 1'b1);
      go_quiet();
      write_config(plan[0]);
      send_byte(8'h78, 1'b0, 1'b0);                          // pad
      send_byte(8'h9C, 1'b0, 1'b1);                          // sum check, offset now zero

      // Random phases
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         go_quiet();
         write_config(plan[ph]);
         req_idle_pct = (ph == 3) ? 0 : 17;
         rsp_idle_pct = (ph == 3) ? 0 : 17;
         if (ph == 4) begin
            hold_request = 1'b1;
         end
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) random_burst();
      end

      go_quiet();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
